### sv/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros for the checker file chm_checker.sv.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/chm_pkg.sv
// ============================================================================
// chm_pkg
// Sizes, codes and controller/datapath interface types of the hash key map.
// ============================================================================
package chm_pkg;

    localparam int BUCKETS       = 1024;
    localparam int NODES         = 256;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_WORDS     = (MAX_KEY_BYTES + 7) / 8;
    localparam int KEY_BYTES     = KEY_WORDS * 8;
    localparam int KIDX_W        = $clog2(KEY_BYTES);
    localparam int KLEN_W        = $clog2(MAX_KEY_BYTES + 2);
    localparam int NODE_W        = $clog2(NODES);
    localparam int PTR_W         = NODE_W + 1;
    localparam int CNT_W         = $clog2(NODES + 1);
    localparam int BKT_W         = $clog2(BUCKETS);
    localparam int BCFG_W        = 11;
    localparam int HASH_W        = 64;
    localparam int HCNT_W        = $clog2(HASH_W);
    localparam int CLR_N         = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLR_W         = $clog2(CLR_N);

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

    localparam int STAT_W = 3;
    localparam int VAL_W  = 32;
    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FOUND     = 3'd4,
        STAT_POOL_FULL = 3'd5,
        STAT_TOO_LONG  = 3'd6
    } status_t;

    localparam int IN_TDATA_W    = ((8 + VAL_W + 7) / 8) * 8;
    localparam int OUT_BITS      = STAT_W + VAL_W + CNT_W + 1;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_VAL_LSB   = STAT_W;
    localparam int OUT_CNT_LSB   = STAT_W + VAL_W;
    localparam int OUT_EMPTY_BIT = OUT_CNT_LSB + CNT_W;

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_BUCKET_COUNT = 3'd0;

    typedef struct packed {
        logic clear_step;
        logic byte_take;
        logic div_step;
        logic head_rd;
        logic head_ld;
        logic node_rd;
        logic node_cmp;
        logic act;
        logic alloc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic too_long;
        logic div_last;
        logic cur_null;
        logic key_match;
        logic need_alloc;
    } sts_t;

endpackage

### sv/chained_hash_key_map_unit.sv
// ============================================================================
// chained_hash_key_map_unit
// Key-to-value map with separate chaining over a fixed node pool.
// ============================================================================
// Keys stream in one byte per request on the slave side; a byte without
// tlast is hashed and buffered. The byte with tlast starts the operation
// (tuser selects insert, remove or get) and yields one result on the
// master side. That operation runs the bit-serial remainder unit that
// reduces the 64-bit hash to a bucket, the bucket head read and load, a
// read and a compare per chain node (one node memory read port) plus a
// last check when the walk runs off the end of the chain, and the update
// (with an allocation for a new key) and the result load; a key that is
// too long skips the remainder and the walk. After reset a clearing pass
// initializes the bucket heads and the free list, with s_tready held low.
module chained_hash_key_map_unit import chm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key_byte, value_in
    input  logic [KIND_W-1:0]      s_tuser,   // kind
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status, value_out, entry_count, table_empty
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [BCFG_W-1:0] bucket_count_reg;
    cmd_t              cmd;
    sts_t              sts;
    logic [STAT_W-1:0] res_status;
    logic [VAL_W-1:0]  res_value;
    logic [CNT_W-1:0]  res_count;
    logic              res_empty;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BUCKET_COUNT) ? 32'(bucket_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BCFG_W'(BUCKETS);
        end else if (psel && penable && pwrite && paddr == REG_BUCKET_COUNT) begin
            bucket_count_reg <= pwdata[BCFG_W-1:0];
        end
    end

    chm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .bucket_count (bucket_count_reg),
        .kind         (s_tuser),
        .key_byte     (s_tdata[7:0]),
        .key_last     (s_tlast),
        .value_in     (s_tdata[8 +: VAL_W]),
        .sts          (sts),
        .res_status   (res_status),
        .res_value    (res_value),
        .res_count    (res_count),
        .res_empty    (res_empty)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                      res_empty, res_count, res_value, res_status};

endmodule

### sv/chm_ctrl.sv
// ============================================================================
// chm_ctrl
// Sequencer: clearing pass, key intake, remainder, chain walk, update, result.
// ============================================================================
module chm_ctrl import chm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_KEY, S_DIV, S_HEAD_RD, S_HEAD_LD,
        S_NODE_RD, S_NODE_CMP, S_ACT, S_ALLOC, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_KEY);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = S_KEY;
            end
            S_KEY: begin
                if (s_tvalid) begin
                    cmd.byte_take = 1'b1;
                    if (s_tlast) state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.too_long) begin
                    state_next = S_ACT;
                end else begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last) state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD_LD;
            end
            S_HEAD_LD: begin
                cmd.head_ld = 1'b1;
                state_next  = S_NODE_RD;
            end
            S_NODE_RD: begin
                if (sts.cur_null) begin
                    state_next = S_ACT;
                end else begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_NODE_CMP;
                end
            end
            S_NODE_CMP: begin
                cmd.node_cmp = 1'b1;
                state_next   = sts.key_match ? S_ACT : S_NODE_RD;
            end
            S_ACT: begin
                cmd.act    = 1'b1;
                state_next = sts.need_alloc ? S_ALLOC : S_DONE;
            end
            S_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_KEY;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/chm_dp.sv
// ============================================================================
// chm_dp
// Datapath: hash and key buffer, bit-serial remainder, table memories, result.
// ============================================================================
module chm_dp import chm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [BCFG_W-1:0] bucket_count,
    input  logic [KIND_W-1:0] kind,
    input  logic [7:0]        key_byte,
    input  logic              key_last,
    input  logic [VAL_W-1:0]  value_in,
    output sts_t              sts,
    output logic [STAT_W-1:0] res_status,
    output logic [VAL_W-1:0]  res_value,
    output logic [CNT_W-1:0]  res_count,
    output logic              res_empty
);

    logic [PTR_W-1:0]  heads_mem [BUCKETS];
    logic [PTR_W-1:0]  next_mem  [NODES];
    logic [KEY_BYTES*8-1:0] key_mem [NODES];
    logic [KLEN_W-1:0] len_mem   [NODES];
    logic [VAL_W-1:0]  val_mem   [NODES];
    logic [NODE_W-1:0] stack_mem [NODES];

    logic [PTR_W-1:0]       head_q, next_q;
    logic [KEY_BYTES*8-1:0] key_q;
    logic [KLEN_W-1:0]      len_q;
    logic [VAL_W-1:0]       val_q;
    logic [NODE_W-1:0]      stack_q;

    logic [HASH_W-1:0]              hash_reg, hash_next;
    logic [KEY_BYTES-1:0][7:0]      key_reg, key_next;
    logic [KLEN_W-1:0]              kcnt_reg, kcnt_next;
    logic [KIND_W-1:0]              kind_reg;
    logic [VAL_W-1:0]               val_reg;
    logic [BKT_W-1:0]               rem_reg, rem_next;
    logic [HCNT_W-1:0]              dcnt_reg, dcnt_next;
    logic [PTR_W-1:0]               cur_reg, cur_next, prev_reg, prev_next;
    logic [CNT_W-1:0]               steps_reg, steps_next;
    logic                           found_reg, found_next;
    logic [CNT_W-1:0]               free_reg, free_next, stored_reg, stored_next;
    logic [CLR_W-1:0]               clr_reg, clr_next;
    logic [STAT_W-1:0]              stat_reg, stat_next;
    logic [VAL_W-1:0]               vout_reg, vout_next;

    logic [BCFG_W-1:0] eff;
    logic [BCFG_W-1:0] rem_ext;
    logic              too_long, is_ins, is_rem, need_alloc;

    logic              hw_en, nw_en, kw_en, vw_en, sw_en;
    logic [BKT_W-1:0]  hw_addr;
    logic [PTR_W-1:0]  hw_data, nw_data;
    logic [NODE_W-1:0] nw_addr, kw_addr, vw_addr, sw_addr;
    logic [VAL_W-1:0]  vw_data;
    logic [NODE_W-1:0] sw_data;

    assign eff = (bucket_count == '0) ? BCFG_W'(1) :
                 (bucket_count > BCFG_W'(BUCKETS)) ? BCFG_W'(BUCKETS) : bucket_count;
    assign rem_ext    = {rem_reg, hash_reg[HASH_W-1]};
    assign too_long   = kcnt_reg > KLEN_W'(MAX_KEY_BYTES);
    assign is_ins     = (kind_reg == KIND_INSERT);
    assign is_rem     = (kind_reg == KIND_REMOVE);
    assign need_alloc = !too_long && is_ins && !found_reg && (free_reg != '0);

    assign sts.clear_last = (clr_reg == CLR_W'(CLR_N - 1));
    assign sts.too_long   = too_long;
    assign sts.div_last   = (dcnt_reg == HCNT_W'(HASH_W - 1));
    assign sts.cur_null   = (cur_reg == NULL_PTR);
    assign sts.key_match  = (len_q == kcnt_reg) && (key_q == key_reg);
    assign sts.need_alloc = need_alloc;

    always_comb begin
        hash_next   = hash_reg;
        key_next    = key_reg;
        kcnt_next   = kcnt_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        found_next  = found_reg;
        free_next   = free_reg;
        stored_next = stored_reg;
        clr_next    = clr_reg;
        stat_next   = stat_reg;
        vout_next   = vout_reg;
        hw_en = 1'b0; hw_addr = rem_reg; hw_data = NULL_PTR;
        nw_en = 1'b0; nw_addr = prev_reg[NODE_W-1:0]; nw_data = next_q;
        kw_en = 1'b0; kw_addr = stack_q;
        vw_en = 1'b0; vw_addr = cur_reg[NODE_W-1:0]; vw_data = val_reg;
        sw_en = 1'b0; sw_addr = free_reg[NODE_W-1:0]; sw_data = cur_reg[NODE_W-1:0];

        if (cmd.clear_step) begin
            clr_next = clr_reg + 1'b1;
            if ({1'b0, clr_reg} < (CLR_W+1)'(BUCKETS)) begin
                hw_en   = 1'b1;
                hw_addr = clr_reg[BKT_W-1:0];
                hw_data = NULL_PTR;
            end
            if ({1'b0, clr_reg} < (CLR_W+1)'(NODES)) begin
                sw_en   = 1'b1;
                sw_addr = clr_reg[NODE_W-1:0];
                sw_data = NODE_W'(NODES - 1) - clr_reg[NODE_W-1:0];
            end
        end

        if (cmd.byte_take) begin
            hash_next = (hash_reg << 5) - hash_reg + HASH_W'(key_byte);
            if (kcnt_reg < KLEN_W'(MAX_KEY_BYTES)) begin
                key_next[kcnt_reg[KIDX_W-1:0]] = key_byte;
                kcnt_next = kcnt_reg + 1'b1;
            end else begin
                kcnt_next = KLEN_W'(MAX_KEY_BYTES + 1);
            end
        end

        if (cmd.div_step) begin
            hash_next = hash_reg << 1;
            dcnt_next = dcnt_reg + 1'b1;
            rem_next  = (rem_ext >= eff) ? BKT_W'(rem_ext - eff) : BKT_W'(rem_ext);
        end

        if (cmd.head_ld) begin
            cur_next   = head_q;
            prev_next  = NULL_PTR;
            steps_next = '0;
            found_next = 1'b0;
        end

        if (cmd.node_cmp) begin
            if (sts.key_match) begin
                found_next = 1'b1;
            end else begin
                prev_next  = cur_reg;
                steps_next = steps_reg + 1'b1;
                cur_next   = (steps_reg == CNT_W'(NODES - 1)) ? NULL_PTR : next_q;
            end
        end

        if (cmd.act) begin
            vout_next = '0;
            priority if (too_long) begin
                stat_next = STAT_TOO_LONG;
            end else if (is_ins) begin
                priority if (found_reg) begin
                    vw_en     = 1'b1;
                    stat_next = STAT_UPDATED;
                end else if (free_reg == '0) begin
                    stat_next = STAT_POOL_FULL;
                end else begin
                    stat_next = STAT_INSERTED;
                end
            end else if (is_rem) begin
                if (found_reg) begin
                    if (prev_reg == NULL_PTR) begin
                        hw_en   = 1'b1;
                        hw_data = next_q;
                    end else begin
                        nw_en = 1'b1;
                    end
                    if (free_reg < CNT_W'(NODES)) begin
                        sw_en     = 1'b1;
                        free_next = free_reg + 1'b1;
                    end
                    if (stored_reg != '0) stored_next = stored_reg - 1'b1;
                    stat_next = STAT_REMOVED;
                end else begin
                    stat_next = STAT_NOT_FOUND;
                end
            end else begin
                if (found_reg) begin
                    stat_next = STAT_FOUND;
                    vout_next = val_q;
                end else begin
                    stat_next = STAT_NOT_FOUND;
                end
            end
        end

        if (cmd.alloc) begin
            hw_en       = 1'b1;
            hw_data     = PTR_W'(stack_q);
            nw_en       = 1'b1;
            nw_addr     = stack_q;
            nw_data     = head_q;
            kw_en       = 1'b1;
            vw_en       = 1'b1;
            vw_addr     = stack_q;
            free_next   = free_reg - 1'b1;
            stored_next = stored_reg + 1'b1;
            stat_next   = STAT_INSERTED;
            vout_next   = '0;
        end

        if (cmd.out_load) begin
            hash_next = '0;
            key_next  = '0;
            kcnt_next = '0;
            rem_next  = '0;
            dcnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= '0;
            key_reg    <= '0;
            kcnt_reg   <= '0;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
            free_reg   <= CNT_W'(NODES);
            stored_reg <= '0;
            clr_reg    <= '0;
        end else begin
            hash_reg   <= hash_next;
            key_reg    <= key_next;
            kcnt_reg   <= kcnt_next;
            rem_reg    <= rem_next;
            dcnt_reg   <= dcnt_next;
            free_reg   <= free_next;
            stored_reg <= stored_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
        vout_reg  <= vout_next;
        if (cmd.byte_take && key_last) begin
            kind_reg <= kind;
            val_reg  <= value_in;
        end
        if (cmd.out_load) begin
            res_status <= stat_reg;
            res_value  <= vout_reg;
            res_count  <= stored_reg;
            res_empty  <= (stored_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (hw_en) heads_mem[hw_addr] <= hw_data;
        if (cmd.head_rd) head_q <= heads_mem[rem_reg];
    end

    always_ff @(posedge aclk) begin
        if (nw_en) next_mem[nw_addr] <= nw_data;
        if (cmd.node_rd) next_q <= next_mem[cur_reg[NODE_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (kw_en) begin
            key_mem[kw_addr] <= key_reg;
            len_mem[kw_addr] <= kcnt_reg;
        end
        if (cmd.node_rd) begin
            key_q <= key_mem[cur_reg[NODE_W-1:0]];
            len_q <= len_mem[cur_reg[NODE_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (vw_en) val_mem[vw_addr] <= vw_data;
        if (cmd.node_rd) val_q <= val_mem[cur_reg[NODE_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (sw_en) stack_mem[sw_addr] <= sw_data;
        if (cmd.act && need_alloc) stack_q <= stack_mem[NODE_W'(free_reg - 1'b1)];
    end

endmodule

### sv/chm_checker.sv
// ============================================================================
// chm_checker
// Port-level checks on the result stream of the hash key map.
// ============================================================================
`include "assert_macros.svh"

module chm_checker import chm_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic              out_stall;
    logic [STAT_W-1:0] out_status;
    logic [VAL_W-1:0]  out_value;
    logic [CNT_W-1:0]  out_count;
    logic              out_empty;

    assign out_stall  = m_tvalid && !m_tready;
    assign out_status = m_tdata[STAT_W-1:0];
    assign out_value  = m_tdata[OUT_VAL_LSB +: VAL_W];
    assign out_count  = m_tdata[OUT_CNT_LSB +: CNT_W];
    assign out_empty  = m_tdata[OUT_EMPTY_BIT];

    `CHM_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata), "result moved")
    `CHM_ASSERT_NOW(a_empty, aclk, aresetn, m_tvalid, out_empty == (out_count == '0), "empty flag")
    `CHM_ASSERT_NOW(a_count_max, aclk, aresetn, m_tvalid, out_count <= CNT_W'(NODES), "count high")
    `CHM_ASSERT_NOW(a_val_zero, aclk, aresetn, m_tvalid && out_status != STAT_FOUND, out_value == '0, "value")

endmodule

bind chained_hash_key_map_unit chm_checker u_chm_checker (.*);
